>>> rtl/tmsr_pkg.sv
`timescale 1ns / 1ps

package tmsr_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_SAMPLES = 18;
  localparam int CNT_W       = 5;
  localparam int LIMIT_W     = 12;
  localparam int BUDGET_W    = 4;
  localparam int POS_W       = 5;
  localparam int SUM_W       = 17;
  localparam int DIVISOR_W   = 5;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CNT_W-1:0]    RST_SAMPLE_COUNT = CNT_W'(10);
  localparam logic [LIMIT_W-1:0]  RST_SPREAD_LIMIT = LIMIT_W'(40);
  localparam logic [BUDGET_W-1:0] RST_ROUND_BUDGET = BUDGET_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_SPREAD_LIMIT = 2'd1,
    REG_ROUND_BUDGET = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;
  } smp_beat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   settled;
  } res_beat_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic load_single;
    logic load_quot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic awaiting_dummy;
    logic out_valid;
    logic emit;
    logic single;
    logic div_done;
  } dp_status_t;

  function automatic logic [POS_W-1:0] eff_count(input logic [CNT_W-1:0] count);
    logic [POS_W-1:0] n;
    n = POS_W'(count);
    if (count < CNT_W'(3)) begin
      n = POS_W'(1);
    end else if (count > CNT_W'(MAX_SAMPLES)) begin
      n = POS_W'(MAX_SAMPLES);
    end
    return n;
  endfunction

endpackage

>>> rtl/tmsr_div.sv
`timescale 1ns / 1ps

module tmsr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [tmsr_pkg::SUM_W-1:0]           dividend,
  input  logic [tmsr_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                 done,
  output logic [tmsr_pkg::SUM_W-1:0]           quotient
);

  logic                                busy;
  logic [tmsr_pkg::STEP_W-1:0]         step;
  logic [tmsr_pkg::DIVISOR_W-1:0]      dvs;
  logic [tmsr_pkg::DIVISOR_W-1:0]      rem;
  logic [tmsr_pkg::SUM_W-1:0]          quo;
  logic [tmsr_pkg::DIVISOR_W:0]        trial;
  logic [tmsr_pkg::DIVISOR_W:0]        diff;
  logic                                ge;

  assign trial = {rem, quo[tmsr_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= tmsr_pkg::STEP_W'(tmsr_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        step <= step - tmsr_pkg::STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[tmsr_pkg::SUM_W-2:0], ge};
      rem <= ge ? diff[tmsr_pkg::DIVISOR_W-1:0] : trial[tmsr_pkg::DIVISOR_W-1:0];
    end
  end

endmodule

>>> rtl/tmsr_dp.sv
`timescale 1ns / 1ps

module tmsr_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmsr_pkg::ctrl_cmd_t                  cmd,
  output tmsr_pkg::dp_status_t                 status,
  input  tmsr_pkg::smp_beat_t                  smp,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output tmsr_pkg::res_beat_t                  res,
  input  logic                                 cfg_we,
  input  logic [tmsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [tmsr_pkg::CNT_W-1:0]        sample_count;
  logic [tmsr_pkg::LIMIT_W-1:0]      spread_limit;
  logic [tmsr_pkg::BUDGET_W-1:0]     round_budget;

  logic                              awaiting_dummy;
  logic [tmsr_pkg::POS_W-1:0]        position;
  logic [tmsr_pkg::BUDGET_W-1:0]     rounds_done;
  logic [tmsr_pkg::SAMPLE_BITS-1:0]  round_min;
  logic [tmsr_pkg::SAMPLE_BITS-1:0]  round_max;
  logic [tmsr_pkg::SUM_W-1:0]        round_sum;
  logic                              held_settled;

  logic                              drop;
  logic [tmsr_pkg::SAMPLE_BITS-1:0]  min_next;
  logic [tmsr_pkg::SAMPLE_BITS-1:0]  max_next;
  logic [tmsr_pkg::SUM_W-1:0]        sum_next;
  logic [tmsr_pkg::POS_W-1:0]        position_next;
  logic [tmsr_pkg::POS_W-1:0]        n_eff;
  logic [tmsr_pkg::BUDGET_W:0]       rounds_next;
  logic                              round_end;
  logic                              settled;
  logic                              give_up;
  logic [tmsr_pkg::SUM_W-1:0]        dividend;
  logic [tmsr_pkg::DIVISOR_W-1:0]    divisor;
  logic                              div_done;
  logic [tmsr_pkg::SUM_W-1:0]        quotient;

  assign drop          = smp.restart || awaiting_dummy;
  assign min_next      = (smp.sample < round_min) ? smp.sample : round_min;
  assign max_next      = (smp.sample > round_max) ? smp.sample : round_max;
  assign sum_next      = round_sum + tmsr_pkg::SUM_W'(smp.sample);
  assign position_next = position + tmsr_pkg::POS_W'(1);
  assign n_eff         = tmsr_pkg::eff_count(sample_count);
  assign round_end     = position_next >= n_eff;
  assign settled       = (max_next - min_next) < spread_limit;
  assign rounds_next   = {1'b0, rounds_done} + (tmsr_pkg::BUDGET_W+1)'(1);
  assign give_up       = rounds_next >= {1'b0, round_budget};
  assign dividend      = sum_next - tmsr_pkg::SUM_W'(min_next) - tmsr_pkg::SUM_W'(max_next);
  assign divisor       = tmsr_pkg::DIVISOR_W'(n_eff - tmsr_pkg::POS_W'(2));

  assign status.awaiting_dummy = awaiting_dummy;
  assign status.out_valid      = res_valid;
  assign status.emit           = !drop && round_end && (settled || give_up);
  assign status.single         = n_eff == tmsr_pkg::POS_W'(1);
  assign status.div_done       = div_done;

  tmsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= tmsr_pkg::RST_SAMPLE_COUNT;
      spread_limit <= tmsr_pkg::RST_SPREAD_LIMIT;
      round_budget <= tmsr_pkg::RST_ROUND_BUDGET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmsr_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[tmsr_pkg::CNT_W-1:0];
        tmsr_pkg::REG_SPREAD_LIMIT: spread_limit <= cfg_data[tmsr_pkg::LIMIT_W-1:0];
        tmsr_pkg::REG_ROUND_BUDGET: round_budget <= cfg_data[tmsr_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_dummy <= 1'b1;
      position       <= '0;
      rounds_done    <= '0;
      round_min      <= '1;
      round_max      <= '0;
      round_sum      <= '0;
    end else if (cmd.take) begin
      if (drop) begin
        awaiting_dummy <= 1'b0;
        rounds_done    <= '0;
        position       <= '0;
        round_min      <= '1;
        round_max      <= '0;
        round_sum      <= '0;
      end else if (!round_end) begin
        position  <= position_next;
        round_min <= min_next;
        round_max <= max_next;
        round_sum <= sum_next;
      end else begin
        // close the round: finish the measurement or retry
        if (settled || give_up) begin
          awaiting_dummy <= 1'b1;
          rounds_done    <= '0;
        end else begin
          rounds_done <= rounds_next[tmsr_pkg::BUDGET_W-1:0];
        end
        position  <= '0;
        round_min <= '1;
        round_max <= '0;
        round_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      held_settled <= settled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_quot) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      res.average <= smp.sample;
      res.settled <= settled;
    end else if (cmd.load_quot) begin
      res.average <= quotient[tmsr_pkg::SAMPLE_BITS-1:0];
      res.settled <= held_settled;
    end
  end

endmodule

>>> rtl/tmsr_ctrl.sv
`timescale 1ns / 1ps

module tmsr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   smp_valid,
  output logic                   smp_ready,
  input  tmsr_pkg::dp_status_t   status,
  output tmsr_pkg::ctrl_cmd_t    cmd
);

  tmsr_pkg::state_t state;
  tmsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmsr_pkg::ST_IDLE: begin
        if (cmd.div_start) begin
          state_next = tmsr_pkg::ST_DIV;
        end
      end
      tmsr_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = tmsr_pkg::ST_IDLE;
        end
      end
      default: state_next = tmsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    smp_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      tmsr_pkg::ST_IDLE: begin
        // a waiting result blocks all but the dummy beat
        smp_ready       = !status.out_valid || status.awaiting_dummy;
        cmd.take        = smp_valid && smp_ready;
        cmd.div_start   = cmd.take && status.emit && !status.single;
        cmd.load_single = cmd.take && status.emit && status.single;
      end
      tmsr_pkg::ST_DIV: begin
        cmd.load_quot = status.div_done;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/trimmed_mean_with_spread_retry_top.sv
`timescale 1ns / 1ps

// Channel | Handshake              | Payload
// smp     | smp_valid / smp_ready  | smp.sample, smp.restart
// res     | res_valid / res_ready  | res.average, res.settled
// cfg     | cfg_we (no wait)       | cfg_index, cfg_data
//
// A sample beat that yields no result is taken while smp_ready is high. A beat
// that ends the measurement with one sample per round shows its result the next
// cycle; with three or more it waits on the 17-step shift-subtract divider.
// Reset restores the registers to 10 / 40 / 10; the next sample is the dummy.
// While a result waits on res_ready, only the dummy beat of the next measurement
// is taken.

module trimmed_mean_with_spread_retry_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 smp_valid,
  output logic                                 smp_ready,
  input  tmsr_pkg::smp_beat_t                  smp,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output tmsr_pkg::res_beat_t                  res,
  input  logic                                 cfg_we,
  input  logic [tmsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tmsr_pkg::ctrl_cmd_t  cmd;
  tmsr_pkg::dp_status_t status;

  tmsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tmsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .smp       (smp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
